// File: rtl/bksel_pkg.sv
// Shared types and constants for the bottom-k record selector.
package bksel_pkg;

	localparam int KEEP_COUNT = 25;
	localparam int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam int CNT_W      = $clog2(KEEP_COUNT + 1);
	localparam int KEY_W      = 12;
	localparam int ID_W       = 16;
	localparam int STAT_W     = 10;
	localparam int RANK_W     = 6;

	typedef enum logic [1:0] {
		STAT_POINTS   = 2'd0,
		STAT_ASSISTS  = 2'd1,
		STAT_REBOUNDS = 2'd2,
		STAT_OVERALL  = 2'd3
	} stat_t;

	typedef struct packed {
		logic [ID_W-1:0]   player_id;
		logic [STAT_W-1:0] points_tenths;
		logic [STAT_W-1:0] assists_tenths;
		logic [STAT_W-1:0] rebounds_tenths;
		logic [KEY_W-1:0]  overall_score;
		logic              last;
	} rec_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [ID_W-1:0]   result_id;
		logic [KEY_W-1:0]  result_key;
		logic              final_res;
	} res_t;

	typedef struct packed {
		logic insert;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic emit_final;
	} sts_t;

endpackage

// File: rtl/bksel_dp.sv
// Datapath: sorted record cells with parallel insertion, shift-out and result register.
module bksel_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bksel_pkg::cmd_t    cmd,
	output bksel_pkg::sts_t    sts,
	input  bksel_pkg::rec_t    rec,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_data,
	output logic               res_valid,
	input  logic               res_stall,
	output bksel_pkg::res_t    res
);

	localparam int K  = bksel_pkg::KEEP_COUNT;
	localparam int CW = bksel_pkg::CNT_W;
	localparam int KW = bksel_pkg::KEY_W;
	localparam int RW = bksel_pkg::RANK_W;

	bksel_pkg::stat_t          stat_q;
	logic [KW-1:0]             key_q [K];
	logic [bksel_pkg::ID_W-1:0] id_q [K];
	logic [KW-1:0]             key_d [K];
	logic [bksel_pkg::ID_W-1:0] id_d [K];
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             emit_q;
	logic                      res_valid_q;
	bksel_pkg::res_t           res_q;
	logic [KW-1:0]             new_key;
	logic [K-1:0]              gt;
	logic                      emit_final;

	always_comb begin
		unique case (stat_q)
			bksel_pkg::STAT_POINTS:   new_key = KW'(rec.points_tenths);
			bksel_pkg::STAT_ASSISTS:  new_key = KW'(rec.assists_tenths);
			bksel_pkg::STAT_REBOUNDS: new_key = KW'(rec.rebounds_tenths);
			default:                  new_key = rec.overall_score;
		endcase
	end

	// A cell takes part in the insertion when it is empty or holds a strictly larger key,
	// so equal keys keep arrival order. The cells that do form a suffix of the array.
	always_comb begin
		for (int i = 0; i < K; i++) begin
			gt[i] = !(CW'(i) < cnt_q) || (key_q[i] > new_key);
		end
	end

	always_comb begin
		for (int i = 0; i < K; i++) begin
			key_d[i] = key_q[i];
			id_d[i]  = id_q[i];
		end
		if (cmd.insert) begin
			if (gt[0]) begin
				key_d[0] = new_key;
				id_d[0]  = rec.player_id;
			end
			for (int i = 1; i < K; i++) begin
				if (gt[i]) begin
					if (!gt[i-1]) begin
						key_d[i] = new_key;
						id_d[i]  = rec.player_id;
					end else begin
						key_d[i] = key_q[i-1];
						id_d[i]  = id_q[i-1];
					end
				end
			end
		end else if (cmd.emit) begin
			for (int i = 0; i < K - 1; i++) begin
				key_d[i] = key_q[i+1];
				id_d[i]  = id_q[i+1];
			end
		end
	end

	assign emit_final = (emit_q == (cnt_q - CW'(1)));

	always_ff @(posedge clk) begin
		for (int i = 0; i < K; i++) begin
			key_q[i] <= key_d[i];
			id_q[i]  <= id_d[i];
		end
		if (cmd.emit) begin
			res_q.rank       <= RW'(emit_q);
			res_q.result_id  <= id_q[0];
			res_q.result_key <= key_q[0];
			res_q.final_res  <= emit_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q      <= bksel_pkg::STAT_POINTS;
			cnt_q       <= '0;
			emit_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				stat_q <= bksel_pkg::stat_t'(cfg_data);
			end
			if (cmd.insert && (cnt_q < CW'(K))) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.emit && emit_final) begin
				cnt_q <= '0;
			end
			if (cmd.emit) begin
				emit_q <= emit_final ? '0 : emit_q + CW'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free   = !res_valid_q || !res_stall;
	assign sts.emit_final = emit_final;
	assign res_valid      = res_valid_q;
	assign res            = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(K))
		else $error("kept count exceeds the store size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(res_valid_q && res_stall))
		else $error("result register overwritten while stalled");

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && emit_final) |=> (cnt_q == '0) && (emit_q == '0))
		else $error("store not cleared after the final result");

endmodule

// File: rtl/bksel_ctrl.sv
// Controller: collects records until the last one, then drives the shift-out of results.
module bksel_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rec_valid,
	input  logic            rec_last,
	output logic            rec_stall,
	input  bksel_pkg::sts_t sts,
	output bksel_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_COLLECT = 2'b01,
		ST_EMIT    = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign rec_stall = (state_q != ST_COLLECT);
	assign accept    = rec_valid && !rec_stall;

	always_comb begin
		state_d    = state_q;
		cmd.insert = 1'b0;
		cmd.emit   = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				cmd.insert = accept;
				if (accept && rec_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free && sts.emit_final) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_insert_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !cmd.insert)
		else $error("record inserted while results are going out");

	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rec_last) |=> (state_q == ST_EMIT))
		else $error("last record did not start the result run");

endmodule

// File: rtl/bottom_k_record_selector.sv
// Top level of the bottom-k record selector: controller and datapath.
//
//  Channel  Signals                       Direction  Moves
//  rec      rec_valid, rec_stall, rec     in         one record item
//  res      res_valid, res_stall, res     out        one ranked result item
//  cfg      cfg_valid, cfg_ready, cfg_data in        stat_select write
//
// A record is inserted by a parallel compare-and-shift over the 25 cells.
// The record marked last starts a run of one result per cycle, while res_stall is low,
// as many as records kept; records are stalled during the run.
// The shift-out is paced by the single result register and by res_stall.
// Reset clears the kept count, the key select and the state; the cells need no clearing.
module bottom_k_record_selector (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rec_valid,
	output logic            rec_stall,
	input  bksel_pkg::rec_t rec,
	output logic            res_valid,
	input  logic            res_stall,
	output bksel_pkg::res_t res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_data
);

	bksel_pkg::cmd_t cmd;
	bksel_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bksel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_last  (rec.last),
		.rec_stall (rec_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bksel_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rec       (rec),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// File: tb/bottom_k_record_selector_tb.sv
// Self-checking testbench for the bottom-k record selector with a scoreboard class.
`timescale 1ns / 100ps

module bottom_k_record_selector_tb;

	localparam int TARGET_ITEMS = 380;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 30;
	localparam int HOLD_CYCLES = 120;
	localparam int IDLE_LIMIT = 2000;

	// Tracks the kept records the way the block should and queues the ranked results.
	class rank_board;
		bksel_pkg::stat_t            sel = bksel_pkg::STAT_POINTS;
		logic [bksel_pkg::KEY_W-1:0] keys [bksel_pkg::KEEP_COUNT];
		logic [bksel_pkg::ID_W-1:0]  ids [bksel_pkg::KEEP_COUNT];
		int                          count = 0;
		bksel_pkg::res_t             pending [$];
		int                          errors = 0;

		function void set_stat(bksel_pkg::stat_t s);
			sel = s;
		endfunction

		function void note_record(bksel_pkg::rec_t r);
			logic [bksel_pkg::KEY_W-1:0] key;
			bksel_pkg::res_t             want;
			int                          pos;
			int                          top;
			int                          i;
			case (sel)
				bksel_pkg::STAT_POINTS: key = {2'b00, r.points_tenths};
				bksel_pkg::STAT_ASSISTS: key = {2'b00, r.assists_tenths};
				bksel_pkg::STAT_REBOUNDS: key = {2'b00, r.rebounds_tenths};
				default: key = r.overall_score;
			endcase
			// Equal keys go behind the ones already held, so arrival order survives.
			pos = 0;
			while (pos < count && keys[pos] <= key)
				pos++;
			if (pos < bksel_pkg::KEEP_COUNT) begin
				top = (count < bksel_pkg::KEEP_COUNT) ? count : bksel_pkg::KEEP_COUNT - 1;
				for (i = top; i > pos; i--) begin
					keys[i] = keys[i - 1];
					ids[i] = ids[i - 1];
				end
				keys[pos] = key;
				ids[pos] = r.player_id;
				if (count < bksel_pkg::KEEP_COUNT)
					count++;
			end
			if (r.last) begin
				for (i = 0; i < count; i++) begin
					want.rank = bksel_pkg::RANK_W'(i);
					want.result_id = ids[i];
					want.result_key = keys[i];
					want.final_res = (i == count - 1);
					pending = {pending, want};
				end
				count = 0;
			end
		endfunction

		function void compare_field(string what, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(bksel_pkg::res_t got);
			bksel_pkg::res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result: rank %0d id %0d key %0d final %b",
					$time, got.rank, got.result_id, got.result_key, got.final_res);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("rank", 16'(want.rank), 16'(got.rank));
			compare_field("result_id", want.result_id, got.result_id);
			compare_field("result_key", 16'(want.result_key), 16'(got.result_key));
			compare_field("final_res", 16'(want.final_res), 16'(got.final_res));
		endfunction

		function void report_leftover();
			if (pending.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time, pending.size());
				errors += pending.size();
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            rec_valid;
	logic            rec_stall;
	bksel_pkg::rec_t rec;
	logic            res_valid;
	logic            res_stall;
	bksel_pkg::res_t res;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [1:0]      cfg_data;

	rank_board board = new;
	int        items_sent = 0;
	int        idle_cycles = 0;
	bit        tx_quiet = 1'b0;
	bit        rx_quiet = 1'b0;
	bit        hold_req = 1'b0;

	bottom_k_record_selector dut (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, some short gaps, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// spread 0 covers the full range, 1 crowds values to force ties, 2 uses only the ends.
	function automatic int pick_val(int spread, int top);
		case (spread)
			0: return int'($urandom_range(0, top));
			1: return int'($urandom_range(0, 3));
			default: return ($urandom_range(0, 1) != 0) ? top : 0;
		endcase
	endfunction

	function automatic bksel_pkg::rec_t mk_rec(int id, int pts, int ast, int reb, int ovr,
			bit is_last);
		bksel_pkg::rec_t r;
		r.player_id = bksel_pkg::ID_W'(id);
		r.points_tenths = bksel_pkg::STAT_W'(pts);
		r.assists_tenths = bksel_pkg::STAT_W'(ast);
		r.rebounds_tenths = bksel_pkg::STAT_W'(reb);
		r.overall_score = bksel_pkg::KEY_W'(ovr);
		r.last = is_last;
		return r;
	endfunction

	function automatic bksel_pkg::rec_t rand_rec(int spread, bit is_last);
		return mk_rec(int'($urandom_range(0, 65535)), pick_val(spread, 1023),
			pick_val(spread, 1023), pick_val(spread, 1023), pick_val(spread, 4095), is_last);
	endfunction

	task automatic send_rec(bksel_pkg::rec_t r);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_valid <= 1'b1;
		rec <= r;
		do @(posedge clk); while (rec_stall !== 1'b0);
		board.note_record(r);
		items_sent++;
	endtask

	// Stop offering records, let every expected result drain, then give the block time to clear.
	task automatic settle();
		rec_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_stat(bksel_pkg::stat_t s);
		cfg_valid <= 1'b1;
		cfg_data <= s;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.set_stat(s);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk)
		if (arst_n && res_valid && !res_stall)
			board.check_result(res);

	always @(posedge clk) begin
		if (!arst_n || (rec_valid && !rec_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("bottom_k_record_selector_tb NOT OK");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Result side: random stalls, quiet stretches, and one long hold-off on request.
	initial begin
		int dur;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 49) == 0)
				rx_quiet = !rx_quiet;
			if (hold_req) begin
				hold_req = 1'b0;
				dur = HOLD_CYCLES;
			end else
				dur = pick_gap(rx_quiet);
			if (dur > 0) begin
				res_stall <= 1'b1;
				repeat (dur) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		int set_no;
		int set_size;
		int spread;
		int split;
		int roll;
		int i;
		bit pressured;

		arst_n <= 1'b0;
		rec_valid <= 1'b0;
		rec <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= bksel_pkg::STAT_POINTS;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A set of one record, carrying the largest identifier and statistic.
		write_stat(bksel_pkg::STAT_POINTS);
		send_rec(mk_rec(65535, 1023, 0, 0, 0, 1'b1));

		// Overall score at both ends, with a tie at zero.
		settle();
		write_stat(bksel_pkg::STAT_OVERALL);
		send_rec(mk_rec(0, 0, 1023, 1023, 4095, 1'b0));
		send_rec(mk_rec(1, 5, 5, 5, 0, 1'b0));
		send_rec(mk_rec(2, 7, 7, 7, 0, 1'b0));
		send_rec(mk_rec(3, 0, 0, 0, 2048, 1'b1));

		settle();
		write_stat(bksel_pkg::STAT_ASSISTS);
		send_rec(mk_rec(10, 0, 1023, 0, 0, 1'b0));
		send_rec(mk_rec(11, 1023, 0, 1023, 4095, 1'b0));
		send_rec(mk_rec(12, 0, 0, 0, 0, 1'b1));

		// The key is switched halfway through a set; kept keys must not be recomputed.
		settle();
		write_stat(bksel_pkg::STAT_REBOUNDS);
		send_rec(mk_rec(20, 0, 0, 1023, 0, 1'b0));
		send_rec(mk_rec(21, 1023, 1023, 500, 4095, 1'b0));
		settle();
		write_stat(bksel_pkg::STAT_POINTS);
		send_rec(mk_rec(22, 3, 0, 0, 0, 1'b0));
		send_rec(mk_rec(23, 1023, 0, 0, 0, 1'b1));

		set_no = 0;
		while (items_sent < TARGET_ITEMS) begin
			// The set after the held-off one starts without waiting, so its records pile up.
			if (set_no != 4 && $urandom_range(0, 2) == 0) begin
				settle();
				write_stat(bksel_pkg::stat_t'($urandom_range(0, 3)));
			end
			roll = $urandom_range(0, 99);
			if (roll < 65)
				set_size = $urandom_range(1, 12);
			else if (roll < 95)
				set_size = $urandom_range(20, 35);
			else
				set_size = $urandom_range(40, 60);
			roll = $urandom_range(0, 9);
			spread = (roll < 5) ? 0 : (roll < 8) ? 1 : 2;
			pressured = (set_no == 3);
			if (pressured)
				set_size = 30;
			split = 0;
			if (!pressured && set_size > 1 && $urandom_range(0, 7) == 0)
				split = $urandom_range(1, set_size - 1);
			// Keep offering records back to back while the results are held off.
			tx_quiet = pressured || set_no == 4 || $urandom_range(0, 4) == 0;
			for (i = 0; i < set_size; i++) begin
				if (split != 0 && i == split) begin
					settle();
					write_stat(bksel_pkg::stat_t'($urandom_range(0, 3)));
				end
				if (pressured && i == set_size - 1)
					hold_req = 1'b1;
				send_rec(rand_rec(spread, i == set_size - 1));
			end
			set_no++;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		board.report_leftover();
		if (board.errors == 0)
			$display("bottom_k_record_selector_tb OK");
		else
			$display("bottom_k_record_selector_tb NOT OK");
		$finish;
	end

endmodule
